### rtl/rsi_pkg.sv
// Shared beat types and fixed constants for the ray/sphere intersection core.
package rsi_pkg;

	// Integer square root of the 132-bit discriminant: one result bit per stage
	localparam int SQRT_STEPS = 66;
	// Quotient bits kept below the saturation limit: one bit per stage
	localparam int DIV_STEPS  = 33;

	localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;
	localparam logic [31:0] COORD_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic        [30:0] sphere_radius;
	} ray_t;

	typedef struct packed {
		logic        [1:0]  hit_count;
		logic signed [31:0] near_x;
		logic signed [31:0] near_y;
		logic signed [31:0] near_z;
		logic signed [31:0] far_x;
		logic signed [31:0] far_y;
		logic signed [31:0] far_z;
		logic               degenerate_ray;
		logic               saturated;
	} hit_t;

endpackage

### rtl/ray_sphere_intersection_core.sv
// Ray/sphere intersection core: fully pipelined, one ray beat per cycle while the output is not stalled.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+-----------------------------
//   ray     | in        | ray_valid/ray_stall | ray_t: origin, dir, sphere
//   hit     | out       | hit_valid/hit_stall | hit_t: count, points, flags
//
// Throughput is one beat per cycle while the output is not stalled; the
// pipeline depth is set by the 66-stage bit-per-stage square root and the
// 33-stage bit-per-stage dividers that place the hit points.
// Reset (arst_n low) clears only the valid bits of the pipeline.
// A stalled output beat freezes the whole pipeline; ray_stall rises in the
// same cycle, so no beat is lost or repeated.
module ray_sphere_intersection_core import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic ray_valid,
	output logic ray_stall,
	input  ray_t ray,
	output logic hit_valid,
	input  logic hit_stall,
	output hit_t hit
);

	localparam int LAT = 6 + SQRT_STEPS + 4 + DIV_STEPS + 1;

	typedef logic [2:0][31:0] vec3_t;

	typedef struct packed {
		vec3_t            o;
		vec3_t            d;
		logic [2:0][32:0] dd;
		logic [30:0]      r;
	} s1_t;

	typedef struct packed {
		vec3_t            o;
		vec3_t            d;
		logic [2:0][65:0] dsq;
		logic [2:0][65:0] bd;
		logic [2:0][65:0] ddsq;
		logic [61:0]      rsq;
	} s2_t;

	typedef struct packed {
		vec3_t       o;
		vec3_t       d;
		logic [63:0] a;
		logic [66:0] b;
		logic [67:0] c;
	} s3_t;

	typedef struct packed {
		vec3_t       o;
		vec3_t       d;
		logic [63:0] a;
		logic [66:0] b;
		logic        degen;
		logic        c_neg;
		logic        c_le0;
		logic        c_ge0;
		logic        b_le0;
		logic [65:0] bhh;
		logic [65:0] bhl;
		logic [65:0] bll;
		logic [65:0] ahch;
		logic [65:0] ahcl;
		logic [65:0] alch;
		logic [65:0] alcl;
	} s4_t;

	typedef struct packed {
		vec3_t        o;
		vec3_t        d;
		logic [63:0]  a;
		logic [66:0]  b;
		logic         degen;
		logic         c_neg;
		logic         c_le0;
		logic         c_ge0;
		logic         b_le0;
		logic [131:0] b2;
		logic [131:0] ac;
	} s5_t;

	typedef struct packed {
		vec3_t        o;
		vec3_t        d;
		logic [63:0]  a;
		logic [66:0]  b;
		logic         degen;
		logic [1:0]   cnt;
		logic [131:0] x;
		logic [68:0]  rem;
		logic [65:0]  root;
	} sq_t;

	typedef struct packed {
		vec3_t       o;
		vec3_t       d;
		logic [63:0] a;
		logic        degen;
		logic [1:0]  cnt;
		logic [67:0] nn_mag;
		logic [67:0] nf_mag;
		logic        nn_neg;
		logic        nf_neg;
	} sn_t;

	typedef struct packed {
		vec3_t            o;
		logic [63:0]      a;
		logic             degen;
		logic [1:0]       cnt;
		logic [5:0][65:0] hi;
		logic [5:0][65:0] lo;
		logic [5:0]       neg;
	} pp_t;

	typedef struct packed {
		vec3_t            o;
		logic [63:0]      a;
		logic             degen;
		logic [1:0]       cnt;
		logic [5:0][99:0] p;
		logic [5:0]       neg;
	} pr_t;

	typedef struct packed {
		vec3_t            o;
		logic [63:0]      a;
		logic             degen;
		logic [1:0]       cnt;
		logic [5:0][63:0] rem;
		logic [5:0][32:0] low;
		logic [5:0][32:0] q;
		logic [5:0]       neg;
		logic [5:0]       ovf;
	} dv_t;

	// One restoring square-root step: bring down two radicand bits
	function automatic sq_t sq_step(input sq_t s);
		sq_t         n;
		logic [68:0] r2;
		logic [68:0] tr;
		n  = s;
		r2 = {s.rem[66:0], s.x[131:130]};
		tr = {1'b0, s.root, 2'b01};
		n.x = {s.x[129:0], 2'b00};
		if (r2 >= tr) begin
			n.rem  = r2 - tr;
			n.root = {s.root[64:0], 1'b1};
		end else begin
			n.rem  = r2;
			n.root = {s.root[64:0], 1'b0};
		end
		return n;
	endfunction

	// One restoring division step on all six coordinate lanes
	function automatic dv_t dv_step(input dv_t s);
		dv_t         n;
		logic [64:0] r2;
		logic [64:0] df;
		n = s;
		for (int k = 0; k < 6; k++) begin
			r2 = {s.rem[k], s.low[k][32]};
			df = r2 - {1'b0, s.a};
			if (r2 >= {1'b0, s.a}) begin
				n.rem[k] = df[63:0];
				n.q[k]   = {s.q[k][31:0], 1'b1};
			end else begin
				n.rem[k] = r2[63:0];
				n.q[k]   = {s.q[k][31:0], 1'b0};
			end
			n.low[k] = {s.low[k][31:0], 1'b0};
		end
		return n;
	endfunction

	logic            adv;
	logic [LAT-1:0]  vld_q;

	vec3_t           ctr;
	s1_t             s1_d, s1;
	s2_t             s2_d, s2;
	s3_t             s3_d, s3;
	s4_t             s4_d, s4;
	s5_t             s5_d, s5;
	sq_t             s6_d, s6;
	sq_t             sqrt_s7 [SQRT_STEPS];
	sn_t             sn_d, sn_s8;
	pp_t             pp_d, pp_s9;
	pr_t             pr_d, pr_s10;
	dv_t             dv_d, dv_s11;
	dv_t             div_s12 [DIV_STEPS];
	hit_t            out_d, out_s13;

	logic signed [65:0] m_dsq [3];
	logic signed [65:0] m_bd [3];
	logic signed [65:0] m_ddsq [3];
	logic signed [66:0] a_sum;
	logic signed [66:0] b_sum;
	logic signed [67:0] c_sum;
	logic [66:0]        bmag;
	logic [67:0]        cmag;
	logic [132:0]       e_full;
	logic [68:0]        nb, n0, n1, nsel;
	logic [31:0]        dmag [3];
	logic [34:0]        qv [6];
	logic [34:0]        csum [6];
	logic [31:0]        cval [6];
	logic [5:0]         csat;

	// Advance everything unless the output beat is held
	assign adv       = !(vld_q[LAT-1] && hit_stall);
	assign ray_stall = !adv;
	assign hit_valid = vld_q[LAT-1];
	assign hit       = out_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], ray_valid};
		end
	end

	// Stage 1: offset of the origin from the centre
	always_comb begin
		s1_d.o = {ray.origin_z, ray.origin_y, ray.origin_x};
		s1_d.d = {ray.dir_z, ray.dir_y, ray.dir_x};
		ctr    = {ray.center_z, ray.center_y, ray.center_x};
		for (int i = 0; i < 3; i++) begin
			s1_d.dd[i] = {s1_d.o[i][31], s1_d.o[i]} - {ctr[i][31], ctr[i]};
		end
		s1_d.r = ray.sphere_radius;
	end

	// Stage 2: per-axis products
	always_comb begin
		s2_d.o = s1.o;
		s2_d.d = s1.d;
		for (int i = 0; i < 3; i++) begin
			m_dsq[i]     = $signed(s1.d[i]) * $signed(s1.d[i]);
			m_bd[i]      = $signed(s1.dd[i]) * $signed(s1.d[i]);
			m_ddsq[i]    = $signed(s1.dd[i]) * $signed(s1.dd[i]);
			s2_d.dsq[i]  = m_dsq[i];
			s2_d.bd[i]   = m_bd[i];
			s2_d.ddsq[i] = m_ddsq[i];
		end
		s2_d.rsq = s1.r * s1.r;
	end

	// Stage 3: quadratic coefficients A, B, C
	always_comb begin
		a_sum = '0;
		b_sum = '0;
		c_sum = '0;
		for (int i = 0; i < 3; i++) begin
			a_sum = a_sum + $signed({s2.dsq[i][65], s2.dsq[i]});
			b_sum = b_sum + $signed({s2.bd[i][65], s2.bd[i]});
			c_sum = c_sum + $signed({{2{s2.ddsq[i][65]}}, s2.ddsq[i]});
		end
		c_sum  = c_sum - $signed({6'b0, s2.rsq});
		s3_d.o = s2.o;
		s3_d.d = s2.d;
		s3_d.a = a_sum[63:0];
		s3_d.b = b_sum;
		s3_d.c = c_sum;
	end

	// Stage 4: split B*B and A*C into narrow partial products
	always_comb begin
		bmag = s3.b[66] ? (~s3.b + 67'd1) : s3.b;
		cmag = s3.c[67] ? (~s3.c + 68'd1) : s3.c;
		s4_d.o     = s3.o;
		s4_d.d     = s3.d;
		s4_d.a     = s3.a;
		s4_d.b     = s3.b;
		s4_d.degen = (s3.a == '0);
		s4_d.c_neg = s3.c[67];
		s4_d.c_le0 = s3.c[67] || (s3.c == '0);
		s4_d.c_ge0 = !s3.c[67];
		s4_d.b_le0 = s3.b[66] || (s3.b == '0);
		s4_d.bhh   = bmag[65:33] * bmag[65:33];
		s4_d.bhl   = bmag[65:33] * bmag[32:0];
		s4_d.bll   = bmag[32:0] * bmag[32:0];
		s4_d.ahch  = s3.a[63:33] * cmag[65:33];
		s4_d.ahcl  = s3.a[63:33] * cmag[32:0];
		s4_d.alch  = s3.a[32:0] * cmag[65:33];
		s4_d.alcl  = s3.a[32:0] * cmag[32:0];
	end

	// Stage 5: assemble the wide products
	always_comb begin
		s5_d.o     = s4.o;
		s5_d.d     = s4.d;
		s5_d.a     = s4.a;
		s5_d.b     = s4.b;
		s5_d.degen = s4.degen;
		s5_d.c_neg = s4.c_neg;
		s5_d.c_le0 = s4.c_le0;
		s5_d.c_ge0 = s4.c_ge0;
		s5_d.b_le0 = s4.b_le0;
		s5_d.b2 = {s4.bhh, 66'b0} + {32'b0, s4.bhl, 34'b0} + {66'b0, s4.bll};
		s5_d.ac = {s4.ahch, 66'b0} + {33'b0, s4.ahcl, 33'b0}
			+ {33'b0, s4.alch, 33'b0} + {66'b0, s4.alcl};
	end

	// Stage 6: discriminant and root count
	always_comb begin
		if (s5.c_neg) begin
			e_full = {1'b0, s5.b2} + {1'b0, s5.ac};
		end else begin
			e_full = {1'b0, s5.b2} - {1'b0, s5.ac};
		end
		s6_d.o     = s5.o;
		s6_d.d     = s5.d;
		s6_d.a     = s5.a;
		s6_d.b     = s5.b;
		s6_d.degen = s5.degen;
		if (s5.degen || e_full[132]) begin
			s6_d.cnt = 2'd0;
		end else if (e_full == '0) begin
			s6_d.cnt = s5.b_le0 ? 2'd1 : 2'd0;
		end else if (s5.b_le0 && s5.c_ge0) begin
			s6_d.cnt = 2'd2;
		end else if (s5.b_le0 || s5.c_le0) begin
			s6_d.cnt = 2'd1;
		end else begin
			s6_d.cnt = 2'd0;
		end
		s6_d.x    = e_full[131:0];
		s6_d.rem  = '0;
		s6_d.root = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1 <= s1_d;
			s2 <= s2_d;
			s3 <= s3_d;
			s4 <= s4_d;
			s5 <= s5_d;
			s6 <= s6_d;
		end
	end

	// Square root, one result bit per stage
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		if (k == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (adv) sqrt_s7[k] <= sq_step(s6);
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (adv) sqrt_s7[k] <= sq_step(sqrt_s7[k-1]);
			end
		end
	end

	// Numerators -B -/+ S; the near point uses the far root unless both count
	always_comb begin
		nb   = ~{{2{sqrt_s7[SQRT_STEPS-1].b[66]}}, sqrt_s7[SQRT_STEPS-1].b} + 69'd1;
		n0   = nb - {3'b0, sqrt_s7[SQRT_STEPS-1].root};
		n1   = nb + {3'b0, sqrt_s7[SQRT_STEPS-1].root};
		nsel = (sqrt_s7[SQRT_STEPS-1].cnt == 2'd2) ? n0 : n1;
		sn_d.o      = sqrt_s7[SQRT_STEPS-1].o;
		sn_d.d      = sqrt_s7[SQRT_STEPS-1].d;
		sn_d.a      = sqrt_s7[SQRT_STEPS-1].a;
		sn_d.degen  = sqrt_s7[SQRT_STEPS-1].degen;
		sn_d.cnt    = sqrt_s7[SQRT_STEPS-1].cnt;
		sn_d.nn_neg = nsel[68];
		sn_d.nf_neg = n1[68];
		sn_d.nn_mag = nsel[68] ? (~nsel[67:0] + 68'd1) : nsel[67:0];
		sn_d.nf_mag = n1[68] ? (~n1[67:0] + 68'd1) : n1[67:0];
	end

	// Direction times numerator, split in two partial products
	always_comb begin
		pp_d.o     = sn_s8.o;
		pp_d.a     = sn_s8.a;
		pp_d.degen = sn_s8.degen;
		pp_d.cnt   = sn_s8.cnt;
		for (int i = 0; i < 3; i++) begin
			dmag[i] = sn_s8.d[i][31] ? (~sn_s8.d[i] + 32'd1) : sn_s8.d[i];
			pp_d.hi[i]    = dmag[i] * sn_s8.nn_mag[67:34];
			pp_d.lo[i]    = dmag[i] * sn_s8.nn_mag[33:0];
			pp_d.neg[i]   = sn_s8.d[i][31] ^ sn_s8.nn_neg;
			pp_d.hi[i+3]  = dmag[i] * sn_s8.nf_mag[67:34];
			pp_d.lo[i+3]  = dmag[i] * sn_s8.nf_mag[33:0];
			pp_d.neg[i+3] = sn_s8.d[i][31] ^ sn_s8.nf_neg;
		end
	end

	// Sum the partial products
	always_comb begin
		pr_d.o     = pp_s9.o;
		pr_d.a     = pp_s9.a;
		pr_d.degen = pp_s9.degen;
		pr_d.cnt   = pp_s9.cnt;
		pr_d.neg   = pp_s9.neg;
		for (int k = 0; k < 6; k++) begin
			pr_d.p[k] = {pp_s9.hi[k], 34'b0} + {34'b0, pp_s9.lo[k]};
		end
	end

	// Flag quotients too large for a coordinate, seed the dividers
	always_comb begin
		dv_d.o     = pr_s10.o;
		dv_d.a     = pr_s10.a;
		dv_d.degen = pr_s10.degen;
		dv_d.cnt   = pr_s10.cnt;
		dv_d.neg   = pr_s10.neg;
		for (int k = 0; k < 6; k++) begin
			dv_d.ovf[k] = (pr_s10.p[k][99:33] >= {3'b0, pr_s10.a});
			dv_d.rem[k] = pr_s10.p[k][96:33];
			dv_d.low[k] = pr_s10.p[k][32:0];
			dv_d.q[k]   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sn_s8  <= sn_d;
			pp_s9  <= pp_d;
			pr_s10 <= pr_d;
			dv_s11 <= dv_d;
		end
	end

	// Dividers, one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		if (k == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (adv) div_s12[k] <= dv_step(dv_s11);
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (adv) div_s12[k] <= dv_step(div_s12[k-1]);
			end
		end
	end

	// Add the offset to the origin, clamp, drop unreported points
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			qv[k]   = div_s12[DIV_STEPS-1].neg[k] ? (~{2'b0, div_s12[DIV_STEPS-1].q[k]} + 35'd1)
				: {2'b0, div_s12[DIV_STEPS-1].q[k]};
			csum[k] = {{3{div_s12[DIV_STEPS-1].o[k%3][31]}}, div_s12[DIV_STEPS-1].o[k%3]} + qv[k];
			if (div_s12[DIV_STEPS-1].ovf[k]) begin
				cval[k] = div_s12[DIV_STEPS-1].neg[k] ? COORD_MIN : COORD_MAX;
				csat[k] = 1'b1;
			end else if ($signed(csum[k]) > $signed({3'b000, COORD_MAX})) begin
				cval[k] = COORD_MAX;
				csat[k] = 1'b1;
			end else if ($signed(csum[k]) < $signed({3'b111, COORD_MIN})) begin
				cval[k] = COORD_MIN;
				csat[k] = 1'b1;
			end else begin
				cval[k] = csum[k][31:0];
				csat[k] = 1'b0;
			end
			if ((k < 3 && div_s12[DIV_STEPS-1].cnt == 2'd0)
				|| (k >= 3 && div_s12[DIV_STEPS-1].cnt != 2'd2)) begin
				cval[k] = '0;
				csat[k] = 1'b0;
			end
		end
		out_d.hit_count      = div_s12[DIV_STEPS-1].cnt;
		out_d.near_x         = cval[0];
		out_d.near_y         = cval[1];
		out_d.near_z         = cval[2];
		out_d.far_x          = cval[3];
		out_d.far_y          = cval[4];
		out_d.far_z          = cval[5];
		out_d.degenerate_ray = div_s12[DIV_STEPS-1].degen;
		out_d.saturated      = |csat;
	end

	always_ff @(posedge clk) begin
		if (adv) out_s13 <= out_d;
	end

	// A zero direction never reports a hit
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit.degenerate_ray |-> hit.hit_count == 2'd0)
		else $error("degenerate ray with hits");

	// Unreported far point reads zero
	a_far_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit.hit_count != 2'd2 |->
		hit.far_x == '0 && hit.far_y == '0 && hit.far_z == '0)
		else $error("far point set without two hits");

	// No hit means no clamp and no near point
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit.hit_count == 2'd0 |->
		!hit.saturated && hit.near_x == '0 && hit.near_y == '0 && hit.near_z == '0)
		else $error("miss with point or saturation");

	// A held output freezes every valid bit
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit_stall |=> vld_q == $past(vld_q))
		else $error("pipeline moved under stall");

endmodule
